// File: rtl/kasd_pkg.sv
// Shared types, codes and helpers for the keyed archive stream decryptor.
// No dependencies; imported by every module of the block.
package kasd_pkg;

  // Register select values (paddr[2] selects the register)
  localparam logic RegArchiveSize = 1'b0;
  localparam logic RegInitialKey  = 1'b1;

  localparam logic [31:0] ArchiveSizeReset = 32'd8;
  localparam logic [31:0] InitialKeyReset  = 32'hDEAD_CAFE;
  localparam logic [31:0] HeaderBytes      = 32'd8;

  // Parser phases
  localparam logic [2:0] PH_LENGTH  = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_SIZE    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_HALT    = 3'd4;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_BAD_NAME_LEN = 2'd0,
    ERR_OVERRUN      = 2'd1,
    ERR_TRUNCATED    = 2'd2
  } error_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       first_of_archive;
  } kasd_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  plain_byte;
    logic [31:0] entry_size;
    logic [31:0] entry_offset;
    logic [1:0]  error_code;
    logic        last_of_run;
    logic        archive_end;
  } kasd_out_t;

  typedef struct packed {
    logic [31:0] archive_size;
    logic [31:0] initial_key;
  } kasd_cfg_t;

  // key * 7 + 3
  function automatic logic [31:0] next_key(input logic [31:0] k);
    next_key = (k << 3) - k + 32'd3;
  endfunction

  function automatic kasd_out_t error_beat(input error_e code);
    kasd_out_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    error_beat = r;
  endfunction

endpackage

// File: rtl/kasd_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is a parameter; no package dependency.
interface kasd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/kasd_regs.sv
// APB-style configuration registers: archive_size and initial_key.
// Depends on kasd_pkg.
module kasd_regs import kasd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output kasd_cfg_t   cfg_o
);

  kasd_cfg_t cfg_q;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.archive_size <= ArchiveSizeReset;
      cfg_q.initial_key  <= InitialKeyReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegArchiveSize: cfg_q.archive_size <= pwdata;
        RegInitialKey:  cfg_q.initial_key  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegArchiveSize: prdata = cfg_q.archive_size;
      RegInitialKey:  prdata = cfg_q.initial_key;
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/keyed_archive_stream_decryptor.sv
// Top level of the keyed archive stream decryptor: input stage, parser and
// decrypt logic, result register. Depends on kasd_pkg, kasd_stream_if, kasd_regs.
//
// Takes the archive body one byte per beat from offset 8 on and gives at
// most one result beat per byte: a name byte, an entry record (size and
// payload offset), a payload byte or an error. One byte per clock is
// sustained while the output is ready; a byte passes through the input
// register and then the result register. The parser state and both key
// registers update once per byte through a single key step (shift,
// subtract, add). The result register lets a new byte enter while an
// earlier result waits. Configure only while no bytes are in flight;
// initial_key applies at the next first_of_archive beat.
module keyed_archive_stream_decryptor import kasd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kasd_stream_if.sink   in_i,
  kasd_stream_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kasd_cfg_t cfg;

  kasd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage
  logic      s1_valid_q;
  kasd_in_t  s1_q;
  logic      s1_adv;

  // result register
  logic      out_valid_q;
  kasd_out_t out_q;

  // parser state
  logic [2:0]  phase_q,  phase_d;
  logic [31:0] ikey_q,   ikey_d;
  logic [31:0] pkey_q,   pkey_d;
  logic [1:0]  lane_q,   lane_d;
  logic [31:0] fs_q,     fs_d;
  logic [1:0]  fbc_q,    fbc_d;
  logic [31:0] rem_q,    rem_d;
  logic [31:0] pos_q,    pos_d;

  // state after an optional restart
  logic [2:0]  e_phase;
  logic [31:0] e_ikey, e_pkey, e_fs, e_rem, e_pos;
  logic [1:0]  e_lane, e_fbc;

  logic [31:0] fs_new, field_v, rem_m1, key_word;
  logic [32:0] off, off_end;
  logic        at_last, err_done, has_res;
  kasd_out_t   res;

  assign s1_adv      = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    e_phase = phase_q;
    e_ikey  = ikey_q;
    e_pkey  = pkey_q;
    e_lane  = lane_q;
    e_fs    = fs_q;
    e_fbc   = fbc_q;
    e_rem   = rem_q;
    e_pos   = pos_q;
    if (s1_q.first_of_archive) begin
      e_phase = PH_LENGTH;
      e_ikey  = cfg.initial_key;
      e_pkey  = '0;
      e_lane  = '0;
      e_fs    = '0;
      e_fbc   = '0;
      e_rem   = '0;
      e_pos   = HeaderBytes;
    end

    fs_new   = e_fs | ({24'd0, s1_q.stream_byte} << {e_fbc, 3'b000});
    field_v  = fs_new ^ e_ikey;
    rem_m1   = e_rem - 32'd1;
    key_word = e_pkey >> {e_lane, 3'b000};
    off      = {1'b0, e_pos} + 33'd1;
    off_end  = off + {1'b0, field_v};
    at_last  = (e_pos == cfg.archive_size - 32'd1);

    phase_d = e_phase;
    ikey_d  = e_ikey;
    pkey_d  = e_pkey;
    lane_d  = e_lane;
    fs_d    = e_fs;
    fbc_d   = e_fbc;
    rem_d   = e_rem;
    pos_d   = e_pos;

    has_res  = 1'b0;
    err_done = 1'b0;
    res      = '0;

    if (e_phase < PH_HALT) begin
      if (e_pos >= cfg.archive_size) begin
        res     = error_beat(ERR_TRUNCATED);
        has_res = 1'b1;
        phase_d = PH_HALT;
      end else begin
        pos_d = off[31:0];
        unique case (e_phase) inside
          PH_LENGTH, PH_SIZE: begin
            if (e_fbc != 2'd3) begin
              fs_d  = fs_new;
              fbc_d = e_fbc + 2'd1;
            end else begin
              ikey_d = next_key(e_ikey);
              fs_d   = '0;
              fbc_d  = '0;
              if (e_phase == PH_LENGTH) begin
                if (field_v == 32'd0 || field_v > cfg.archive_size) begin
                  res      = error_beat(ERR_BAD_NAME_LEN);
                  has_res  = 1'b1;
                  err_done = 1'b1;
                  phase_d  = PH_HALT;
                end else begin
                  rem_d   = field_v;
                  phase_d = PH_NAME;
                end
              end else begin
                if (off_end > {1'b0, cfg.archive_size}) begin
                  res      = error_beat(ERR_OVERRUN);
                  has_res  = 1'b1;
                  err_done = 1'b1;
                  phase_d  = PH_HALT;
                end else begin
                  pkey_d           = next_key(e_ikey);
                  lane_d           = '0;
                  rem_d            = field_v;
                  phase_d          = (field_v != 32'd0) ? PH_PAYLOAD : PH_LENGTH;
                  res.kind         = KIND_ENTRY;
                  res.entry_size   = field_v;
                  res.entry_offset = off[31:0];
                  has_res          = 1'b1;
                end
              end
            end
          end
          PH_NAME: begin
            res.kind       = KIND_NAME;
            res.plain_byte = s1_q.stream_byte ^ e_ikey[7:0];
            ikey_d         = next_key(e_ikey);
            rem_d          = rem_m1;
            has_res        = 1'b1;
            if (rem_m1 == 32'd0) begin
              res.last_of_run = 1'b1;
              phase_d         = PH_SIZE;
            end
          end
          PH_PAYLOAD: begin
            res.kind       = KIND_PAYLOAD;
            res.plain_byte = s1_q.stream_byte ^ key_word[7:0];
            lane_d         = e_lane + 2'd1;
            if (e_lane == 2'd3) begin
              pkey_d = next_key(e_pkey);
            end
            rem_d   = rem_m1;
            has_res = 1'b1;
            if (rem_m1 == 32'd0) begin
              res.last_of_run = 1'b1;
              phase_d         = PH_LENGTH;
            end
          end
          default: ;
        endcase

        if (at_last && !err_done) begin
          if (phase_d != PH_LENGTH || fbc_d != 2'd0 || !has_res) begin
            res     = error_beat(ERR_TRUNCATED);
            has_res = 1'b1;
          end else begin
            res.archive_end = 1'b1;
          end
          phase_d = PH_HALT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_LENGTH;
      ikey_q      <= InitialKeyReset;
      pkey_q      <= '0;
      lane_q      <= '0;
      fs_q        <= '0;
      fbc_q       <= '0;
      rem_q       <= '0;
      pos_q       <= HeaderBytes;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && has_res;
      end
      if (s1_valid_q && s1_adv) begin
        phase_q <= phase_d;
        ikey_q  <= ikey_d;
        pkey_q  <= pkey_d;
        lane_q  <= lane_d;
        fs_q    <= fs_d;
        fbc_q   <= fbc_d;
        rem_q   <= rem_d;
        pos_q   <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_i.payload;
    end
    if (s1_adv && s1_valid_q && has_res) begin
      out_q <= res;
    end
  end

endmodule
